[hdl/dvtt_pkg.sv]
package dvtt_pkg;

   localparam int V_W   = 22;
   localparam int T_W   = 16;
   localparam int ST_W  = 3;
   localparam int CNT_W = 9;
   localparam int NUM_W = V_W + T_W;

   localparam logic [V_W-1:0] FULL_SCALE_UV = 22'd3000000;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_INVALID = 3'd1;
   localparam logic [ST_W-1:0] ST_OVER    = 3'd2;
   localparam logic [ST_W-1:0] ST_UNDER   = 3'd3;
   localparam logic [ST_W-1:0] ST_FLAT    = 3'd4;

   typedef struct packed {
      logic [V_W-1:0] microvolts;
      logic [T_W-1:0] centikelvin;
   } entry_type;

endpackage

[hdl/dvtt_ram.sv]
module dvtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/dvtt_div.sv]
module dvtt_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dvtt_pkg::NUM_W-1:0]  dividend,
   input  logic [dvtt_pkg::V_W-1:0]    divisor,
   output logic                        done,
   output logic [dvtt_pkg::T_W-1:0]    quotient
);

   // The quotient is known to fit in T_W bits, so the remainder starts with the
   // upper dividend bits and one quotient bit is produced per cycle.
   localparam int STEP_W = $clog2(dvtt_pkg::T_W + 1);

   logic [dvtt_pkg::V_W-1:0]  rem_ff, rem_in;
   logic [dvtt_pkg::T_W-1:0]  low_ff, low_in;
   logic [dvtt_pkg::T_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0]         count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [dvtt_pkg::V_W:0]    trial;
   logic                      fits;

   always_comb begin
      trial    = {rem_ff, low_ff[dvtt_pkg::T_W-1]};
      fits     = trial >= {1'b0, divisor};
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = dividend[dvtt_pkg::NUM_W-1:dvtt_pkg::T_W];
         low_in   = dividend[dvtt_pkg::T_W-1:0];
         count_in = STEP_W'(dvtt_pkg::T_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = dvtt_pkg::V_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[dvtt_pkg::V_W-1:0];
         end
         low_in   = {low_ff[dvtt_pkg::T_W-2:0], 1'b0};
         quo_in   = {quo_ff[dvtt_pkg::T_W-2:0], fits};
         count_in = count_ff - STEP_W'(1);
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/diode_voltage_to_temperature.sv]
// Diode sensor linearizer: turns a converter sample into hundredths of kelvin
// through a calibration table of falling voltages and rising or falling temperatures.
// Requests arrive on req_; tuser selects a table load or a conversion.
// A load writes one table entry and gives no result.
// A conversion gives one result on rsp_: the temperature and a status code.
// The entry count must be written on csr_ only while idle; the block does not check.
// A conversion steps through the states MUL, CHECK, SCAN over the table entries,
// DIFF, PROD, DIV and OUT before its result is presented, and the next request is
// taken once it leaves OUT. The table scan through the single read port of the table
// memory and the bit-serial divider set its length. Errors end early; an invalid
// sample goes straight from idle to the output state.
// The block takes no new request until the current conversion has moved its
// result into the output register. While the receiver stalls, that result
// holds, and a further conversion waits in its last state for the register.
// Reset clears the control logic and sets the entry count to two; the table
// itself is not cleared, and every entry used must be loaded before use.
module diode_voltage_to_temperature #(
   parameter int TABLE_DEPTH = 256,
   parameter int ADC_BITS    = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // entry_index, entry_microvolts, entry_centikelvin, adc_code, sample_valid, zeros
   input  logic [((47 + ADC_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // op
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // temperature_centikelvin, status, zeros
   output logic [23:0]                           rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dvtt_pkg::CNT_W-1:0]            csr_data
);

   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int NW  = (IW + 1 > dvtt_pkg::CNT_W) ? IW + 1 : dvtt_pkg::CNT_W;
   localparam int PW  = ADC_BITS + dvtt_pkg::V_W;
   localparam int V_W = dvtt_pkg::V_W;
   localparam int T_W = dvtt_pkg::T_W;
   localparam int ADC_LO = 46;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DIFF  = 3'd4;
   localparam logic [2:0] S_PROD  = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [7:0]          in_index;
   logic [V_W-1:0]      in_uv;
   logic [T_W-1:0]      in_ck;
   logic [ADC_BITS-1:0] in_code;
   logic                in_valid;

   assign in_index = req_tdata[7:0];
   assign in_uv    = req_tdata[29:8];
   assign in_ck    = req_tdata[45:30];
   assign in_code  = req_tdata[ADC_LO +: ADC_BITS];
   assign in_valid = req_tdata[ADC_LO + ADC_BITS];

   logic [2:0]                  state_ff, state_in;
   logic [IW-1:0]               idx_ff, idx_in;
   logic [dvtt_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [ADC_BITS-1:0]         code_ff, code_in;
   logic [V_W-1:0]              v_ff, v_in;
   logic [V_W-1:0]              prev_v_ff, prev_v_in;
   logic [T_W-1:0]              prev_t_ff, prev_t_in;
   logic [V_W-1:0]              cur_v_ff, cur_v_in;
   logic [T_W-1:0]              cur_t_ff, cur_t_in;
   logic [V_W-1:0]              d_ff, d_in;
   logic [V_W-1:0]              x_ff, x_in;
   logic [T_W-1:0]              dt_ff, dt_in;
   logic                        neg_ff, neg_in;
   logic [dvtt_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [T_W-1:0]              res_t_ff, res_t_in;
   logic [dvtt_pkg::ST_W-1:0]   res_st_ff, res_st_in;
   logic                        out_valid_ff, out_valid_in;
   logic [T_W-1:0]              out_t_ff, out_t_in;
   logic [dvtt_pkg::ST_W-1:0]   out_st_ff, out_st_in;

   logic                        accept;
   logic                        wr_en;
   dvtt_pkg::entry_type         wr_entry;
   dvtt_pkg::entry_type         rd_entry;
   logic [PW-1:0]               prod;
   logic [NW-1:0]               n_eff;
   logic [NW-1:0]               next_pos;
   logic                        div_start;
   logic                        div_done;
   logic [T_W-1:0]              quotient;
   logic                        out_free;

   assign accept    = req_tvalid && req_tready;
   assign req_tready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || rsp_tready;

   assign wr_en = accept && (req_tuser == dvtt_pkg::OP_LOAD)
                  && (32'(in_index) < TABLE_DEPTH);
   assign wr_entry.microvolts  = in_uv;
   assign wr_entry.centikelvin = in_ck;

   dvtt_ram #(
      .WIDTH ($bits(dvtt_pkg::entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IW'(in_index)),
      .wr_data (wr_entry),
      .rd_addr (idx_in),
      .rd_data (rd_entry)
   );

   assign div_start = state_ff == S_PROD;

   dvtt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_in),
      .divisor  (d_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign prod     = PW'(code_ff) * PW'(dvtt_pkg::FULL_SCALE_UV);
   assign n_eff    = (NW'(count_ff) > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_ff);
   assign next_pos = NW'(idx_ff) + NW'(1);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      code_in   = code_ff;
      v_in      = v_ff;
      prev_v_in = prev_v_ff;
      prev_t_in = prev_t_ff;
      cur_v_in  = cur_v_ff;
      cur_t_in  = cur_t_ff;
      d_in      = d_ff;
      x_in      = x_ff;
      dt_in     = dt_ff;
      neg_in    = neg_ff;
      num_in    = num_ff;
      res_t_in  = res_t_ff;
      res_st_in = res_st_ff;

      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept && (req_tuser == dvtt_pkg::OP_CONVERT)) begin
               code_in = in_code;
               if (in_valid) begin
                  state_in = S_MUL;
               end else begin
                  res_t_in  = '0;
                  res_st_in = dvtt_pkg::ST_INVALID;
                  state_in  = S_OUT;
               end
            end
         end
         S_MUL: begin
            v_in     = prod[PW-1:ADC_BITS];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            prev_v_in = rd_entry.microvolts;
            prev_t_in = rd_entry.centikelvin;
            res_t_in  = '0;
            if (v_ff > rd_entry.microvolts) begin
               res_st_in = dvtt_pkg::ST_OVER;
               state_in  = S_OUT;
            end else if (n_eff < NW'(2)) begin
               res_st_in = dvtt_pkg::ST_UNDER;
               state_in  = S_OUT;
            end else begin
               idx_in   = IW'(1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (v_ff >= rd_entry.microvolts) begin
               cur_v_in = rd_entry.microvolts;
               cur_t_in = rd_entry.centikelvin;
               state_in = S_DIFF;
            end else begin
               prev_v_in = rd_entry.microvolts;
               prev_t_in = rd_entry.centikelvin;
               if (next_pos >= n_eff) begin
                  res_t_in  = '0;
                  res_st_in = dvtt_pkg::ST_UNDER;
                  state_in  = S_OUT;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         S_DIFF: begin
            d_in = prev_v_ff - cur_v_ff;
            x_in = v_ff - cur_v_ff;
            if (prev_t_ff >= cur_t_ff) begin
               dt_in  = prev_t_ff - cur_t_ff;
               neg_in = 1'b0;
            end else begin
               dt_in  = cur_t_ff - prev_t_ff;
               neg_in = 1'b1;
            end
            if (prev_v_ff <= cur_v_ff) begin
               res_t_in  = '0;
               res_st_in = dvtt_pkg::ST_FLAT;
               state_in  = S_OUT;
            end else begin
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            num_in   = dvtt_pkg::NUM_W'(dt_ff) * dvtt_pkg::NUM_W'(x_ff)
                       + dvtt_pkg::NUM_W'(d_ff >> 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               res_t_in  = neg_ff ? cur_t_ff - quotient : cur_t_ff + quotient;
               res_st_in = dvtt_pkg::ST_OK;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_t_in     = out_t_ff;
      out_st_in    = out_st_ff;
      if ((state_ff == S_OUT) && out_free) begin
         out_valid_in = 1'b1;
         out_t_in     = res_t_ff;
         out_st_in    = res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         count_ff     <= dvtt_pkg::CNT_W'(2);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      code_ff   <= code_in;
      v_ff      <= v_in;
      prev_v_ff <= prev_v_in;
      prev_t_ff <= prev_t_in;
      cur_v_ff  <= cur_v_in;
      cur_t_ff  <= cur_t_in;
      d_ff      <= d_in;
      x_ff      <= x_in;
      dt_ff     <= dt_in;
      neg_ff    <= neg_in;
      num_ff    <= num_in;
      res_t_ff  <= res_t_in;
      res_st_ff <= res_st_in;
      out_t_ff  <= out_t_in;
      out_st_ff <= out_st_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_st_ff, out_t_ff};

endmodule
